// ===== hdl/agbkf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agbkf_pkg: shared types and constants for the tilt Kalman filter
// Holds the fixed word widths, register indexes, the micro-op encoding and
// the short program that the sequencer steps through for every sample.
// ----------------------------------------------------------------------------
package agbkf_pkg;

  localparam int DATA_W    = 32;
  localparam int CFG_W     = 21;
  localparam int CFG_IDX_W = 4;
  localparam int STEP_W    = 5;
  localparam int NUM_STEPS = 29;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_STEPS - 1);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_NOISE = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS_NOISE  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MEAS_NOISE  = 4'd3;

  // Configuration reset values.
  localparam logic [CFG_W-1:0] RST_TIME_STEP   = 21'd4194;
  localparam logic [CFG_W-1:0] RST_ANGLE_NOISE = 21'd1049;
  localparam logic [CFG_W-1:0] RST_BIAS_NOISE  = 21'd3146;
  localparam logic [CFG_W-1:0] RST_MEAS_NOISE  = 21'd31457;

  typedef logic signed [DATA_W-1:0] word_t;

  localparam word_t WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } alu_op_t;

  // Operand and destination codes of the shared unit.
  typedef enum logic [4:0] {
    OPD_ANGLE,
    OPD_BIAS,
    OPD_AA,
    OPD_AB,
    OPD_BA,
    OPD_BB,
    OPD_T,
    OPD_D,
    OPD_E,
    OPD_S,
    OPD_K0,
    OPD_K1,
    OPD_Y,
    OPD_DT,
    OPD_QA,
    OPD_QB,
    OPD_R,
    OPD_ACCEL,
    OPD_GYRO
  } opnd_t;

  typedef struct packed {
    alu_op_t op;
    opnd_t   dst;
    opnd_t   a;
    opnd_t   b;
  } uop_t;

  // Saturate a 64-bit signed value to one word.
  function automatic word_t sat_word(logic signed [2*DATA_W-1:0] v);
    word_t r;
    if ((&v[2*DATA_W-1:DATA_W-1]) || !(|v[2*DATA_W-1:DATA_W-1])) begin
      r = v[DATA_W-1:0];
    end else if (v[2*DATA_W-1]) begin
      r = WORD_MIN;
    end else begin
      r = WORD_MAX;
    end
    return r;
  endfunction

  function automatic uop_t mk(alu_op_t op, opnd_t d, opnd_t a, opnd_t b);
    uop_t u;
    u.op  = op;
    u.dst = d;
    u.a   = a;
    u.b   = b;
    return u;
  endfunction

  // Program for one sample: predict, gains, correct, covariance update.
  function automatic uop_t uop_at(logic [STEP_W-1:0] step);
    uop_t u;
    unique case (step)
      5'd0:    u = mk(OP_SUB, OPD_D,     OPD_GYRO,  OPD_BIAS);
      5'd1:    u = mk(OP_MUL, OPD_D,     OPD_DT,    OPD_D);
      5'd2:    u = mk(OP_ADD, OPD_ANGLE, OPD_ANGLE, OPD_D);
      5'd3:    u = mk(OP_MUL, OPD_T,     OPD_DT,    OPD_BB);
      5'd4:    u = mk(OP_SUB, OPD_D,     OPD_T,     OPD_AB);
      5'd5:    u = mk(OP_SUB, OPD_D,     OPD_D,     OPD_BA);
      5'd6:    u = mk(OP_ADD, OPD_D,     OPD_D,     OPD_QA);
      5'd7:    u = mk(OP_MUL, OPD_D,     OPD_DT,    OPD_D);
      5'd8:    u = mk(OP_ADD, OPD_AA,    OPD_AA,    OPD_D);
      5'd9:    u = mk(OP_SUB, OPD_AB,    OPD_AB,    OPD_T);
      5'd10:   u = mk(OP_SUB, OPD_BA,    OPD_BA,    OPD_T);
      5'd11:   u = mk(OP_MUL, OPD_D,     OPD_QB,    OPD_DT);
      5'd12:   u = mk(OP_ADD, OPD_BB,    OPD_BB,    OPD_D);
      5'd13:   u = mk(OP_ADD, OPD_S,     OPD_AA,    OPD_R);
      5'd14:   u = mk(OP_DIV, OPD_K0,    OPD_AA,    OPD_S);
      5'd15:   u = mk(OP_DIV, OPD_K1,    OPD_BA,    OPD_S);
      5'd16:   u = mk(OP_SUB, OPD_Y,     OPD_ACCEL, OPD_ANGLE);
      5'd17:   u = mk(OP_MUL, OPD_D,     OPD_K0,    OPD_Y);
      5'd18:   u = mk(OP_ADD, OPD_ANGLE, OPD_ANGLE, OPD_D);
      5'd19:   u = mk(OP_MUL, OPD_D,     OPD_K1,    OPD_Y);
      5'd20:   u = mk(OP_ADD, OPD_BIAS,  OPD_BIAS,  OPD_D);
      5'd21:   u = mk(OP_MUL, OPD_D,     OPD_K0,    OPD_AA);
      5'd22:   u = mk(OP_MUL, OPD_E,     OPD_K1,    OPD_AA);
      5'd23:   u = mk(OP_SUB, OPD_AA,    OPD_AA,    OPD_D);
      5'd24:   u = mk(OP_SUB, OPD_BA,    OPD_BA,    OPD_E);
      5'd25:   u = mk(OP_MUL, OPD_D,     OPD_K0,    OPD_AB);
      5'd26:   u = mk(OP_MUL, OPD_E,     OPD_K1,    OPD_AB);
      5'd27:   u = mk(OP_SUB, OPD_AB,    OPD_AB,    OPD_D);
      5'd28:   u = mk(OP_SUB, OPD_BB,    OPD_BB,    OPD_E);
      default: u = mk(OP_ADD, OPD_D,     OPD_D,     OPD_D);
    endcase
    return u;
  endfunction

endpackage

// ===== hdl/agbkf_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agbkf_in_if: sample channel
// Carries one accelerometer angle and one gyro rate per beat.
// ----------------------------------------------------------------------------
interface agbkf_in_if;
  import agbkf_pkg::*;

  logic  valid;
  logic  ready;
  word_t accel_angle;
  word_t gyro_rate;

  modport source (output valid, output accel_angle, output gyro_rate, input ready);
  modport sink   (input valid, input accel_angle, input gyro_rate, output ready);
endinterface

// ===== hdl/agbkf_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agbkf_out_if: estimate channel
// Carries one filtered angle per beat.
// ----------------------------------------------------------------------------
interface agbkf_out_if;
  import agbkf_pkg::*;

  logic  valid;
  logic  ready;
  word_t angle_estimate;

  modport source (output valid, output angle_estimate, input ready);
  modport sink   (input valid, input angle_estimate, output ready);
endinterface

// ===== hdl/angle_gyro_bias_kalman_filter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// angle_gyro_bias_kalman_filter: two-state tilt Kalman filter
// Fuses an accelerometer angle with a gyro rate, tracks the gyro bias and
// returns the filtered angle, with one shared saturating add/multiply unit
// and a serial divider under a micro-op sequencer.
// ----------------------------------------------------------------------------
//
//  Channel    Dir  Beat contents                      Handshake
//  ---------  ---  ---------------------------------  -------------------
//  sample     in   accel_angle, gyro_rate             valid / ready
//  estimate   out  angle_estimate                     valid / ready
//  cfg        in   cfg_index, cfg_data                cfg_we, no stall
//
//  Each sample runs a program of 27 micro-ops on the shared add/multiply
//  unit and two gain divisions, each set by the 32 iterations of the serial
//  divider, then loads the output register and returns to idle. A division
//  whose quotient overflows a word ends without iterating, and one whose
//  innovation covariance is not positive writes a zero gain without starting
//  the divider. sample.ready is high only while the sequencer is idle. The
//  result sits in an output register; a stalled estimate holds the next result
//  at the end of its program. Reset clears the state and covariance and loads
//  the default configuration.
// ----------------------------------------------------------------------------
module angle_gyro_bias_kalman_filter #(
  parameter int FRAC_BITS = 20
) (
  input  logic                            clk,
  input  logic                            rst,
  agbkf_in_if.sink                        sample,
  agbkf_out_if.source                     estimate,
  input  logic                            cfg_we,
  input  logic [agbkf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [agbkf_pkg::CFG_W-1:0]     cfg_data
);
  import agbkf_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RUN  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t              state;
  logic [STEP_W-1:0]   step;

  // Configuration registers.
  logic [CFG_W-1:0]    time_step;
  logic [CFG_W-1:0]    angle_process_noise;
  logic [CFG_W-1:0]    bias_process_noise;
  logic [CFG_W-1:0]    measurement_noise;

  // Filter state and scratch registers.
  word_t angle_state, bias_state, cov_aa, cov_ab, cov_ba, cov_bb;
  word_t t_reg, d_reg, e_reg, s_reg, k0_reg, k1_reg, y_reg;
  word_t accel_reg, gyro_reg;

  logic                out_valid;
  word_t               out_angle;

  uop_t                uop;
  word_t               opa;
  word_t               opb;
  logic signed [2*DATA_W-1:0] opa_x;
  logic signed [2*DATA_W-1:0] opb_x;
  logic signed [2*DATA_W-1:0] prod;
  logic signed [2*DATA_W-1:0] prod_sh;
  word_t               res;
  logic                s_pos;
  logic                wr_en;
  logic                div_start;
  logic                div_done;
  word_t               div_quot;
  logic                out_load;

  assign sample.ready            = (state == ST_IDLE);
  assign estimate.valid          = out_valid;
  assign estimate.angle_estimate = out_angle;

  assign uop = uop_at(step);

  // Operand selection for the shared unit.
  function automatic word_t pick(opnd_t code, word_t ang, word_t bia, word_t aa,
                                 word_t ab, word_t ba, word_t bb, word_t t,
                                 word_t d, word_t e, word_t s, word_t k0,
                                 word_t k1, word_t y, word_t acc, word_t gyr,
                                 logic [CFG_W-1:0] dt, logic [CFG_W-1:0] qa,
                                 logic [CFG_W-1:0] qb, logic [CFG_W-1:0] r);
    word_t v;
    unique case (code)
      OPD_ANGLE: v = ang;
      OPD_BIAS:  v = bia;
      OPD_AA:    v = aa;
      OPD_AB:    v = ab;
      OPD_BA:    v = ba;
      OPD_BB:    v = bb;
      OPD_T:     v = t;
      OPD_D:     v = d;
      OPD_E:     v = e;
      OPD_S:     v = s;
      OPD_K0:    v = k0;
      OPD_K1:    v = k1;
      OPD_Y:     v = y;
      OPD_DT:    v = word_t'({{(DATA_W-CFG_W){1'b0}}, dt});
      OPD_QA:    v = word_t'({{(DATA_W-CFG_W){1'b0}}, qa});
      OPD_QB:    v = word_t'({{(DATA_W-CFG_W){1'b0}}, qb});
      OPD_R:     v = word_t'({{(DATA_W-CFG_W){1'b0}}, r});
      OPD_ACCEL: v = acc;
      OPD_GYRO:  v = gyr;
      default:   v = '0;
    endcase
    return v;
  endfunction

  always_comb begin
    opa = pick(uop.a, angle_state, bias_state, cov_aa, cov_ab, cov_ba, cov_bb,
               t_reg, d_reg, e_reg, s_reg, k0_reg, k1_reg, y_reg, accel_reg,
               gyro_reg, time_step, angle_process_noise, bias_process_noise,
               measurement_noise);
    opb = pick(uop.b, angle_state, bias_state, cov_aa, cov_ab, cov_ba, cov_bb,
               t_reg, d_reg, e_reg, s_reg, k0_reg, k1_reg, y_reg, accel_reg,
               gyro_reg, time_step, angle_process_noise, bias_process_noise,
               measurement_noise);
  end

  // Shared unit: saturating add, subtract, floor-shifted multiply, quotient.
  always_comb begin
    opa_x   = opa;
    opb_x   = opb;
    prod    = opa_x * opb_x;
    prod_sh = prod >>> FRAC_BITS;
    s_pos   = (opb > 0);
    case (uop.op)
      OP_ADD:  res = sat_word(opa_x + opb_x);
      OP_SUB:  res = sat_word(opa_x - opb_x);
      OP_MUL:  res = sat_word(prod_sh);
      default: res = (state == ST_DIV) ? div_quot : '0;
    endcase
  end

  // A divide with a non-positive innovation covariance writes a zero gain.
  always_comb begin
    div_start = (state == ST_RUN) && (uop.op == OP_DIV) && s_pos;
    wr_en     = ((state == ST_RUN) && !div_start) || ((state == ST_DIV) && div_done);
    out_load  = (state == ST_DONE) && (!out_valid || estimate.ready);
  end

  agbkf_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .numer (opa),
    .denom (opb),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (sample.valid) begin
            state <= ST_RUN;
            step  <= '0;
          end
        end
        ST_RUN, ST_DIV: begin
          if (div_start) begin
            state <= ST_DIV;
          end else if (wr_en) begin
            if (step == LAST_STEP) begin
              state <= ST_DONE;
            end else begin
              state <= ST_RUN;
              step  <= step + STEP_W'(1);
            end
          end
        end
        ST_DONE: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (estimate.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_angle <= angle_state;
    end
  end

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      time_step           <= RST_TIME_STEP;
      angle_process_noise <= RST_ANGLE_NOISE;
      bias_process_noise  <= RST_BIAS_NOISE;
      measurement_noise   <= RST_MEAS_NOISE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TIME_STEP:   time_step           <= cfg_data;
        CFG_ANGLE_NOISE: angle_process_noise <= cfg_data;
        CFG_BIAS_NOISE:  bias_process_noise  <= cfg_data;
        CFG_MEAS_NOISE:  measurement_noise   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Filter state write-back.
  always_ff @(posedge clk) begin
    if (rst) begin
      angle_state <= '0;
      bias_state  <= '0;
      cov_aa      <= '0;
      cov_ab      <= '0;
      cov_ba      <= '0;
      cov_bb      <= '0;
    end else if (wr_en) begin
      case (uop.dst)
        OPD_ANGLE: angle_state <= res;
        OPD_BIAS:  bias_state  <= res;
        OPD_AA:    cov_aa      <= res;
        OPD_AB:    cov_ab      <= res;
        OPD_BA:    cov_ba      <= res;
        OPD_BB:    cov_bb      <= res;
        default: ;
      endcase
    end
  end

  // Scratch write-back and sample capture.
  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      accel_reg <= sample.accel_angle;
      gyro_reg  <= sample.gyro_rate;
    end
    if (wr_en) begin
      case (uop.dst)
        OPD_T:   t_reg  <= res;
        OPD_D:   d_reg  <= res;
        OPD_E:   e_reg  <= res;
        OPD_S:   s_reg  <= res;
        OPD_K0:  k0_reg <= res;
        OPD_K1:  k1_reg <= res;
        OPD_Y:   y_reg  <= res;
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/agbkf_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agbkf_div: serial fixed-point divider
// Computes (numer * 2^FRAC_BITS) / denom, truncated toward zero and
// saturated to one word, one quotient bit per cycle. denom must be positive.
// ----------------------------------------------------------------------------
module agbkf_div #(
  parameter int FRAC_BITS = 20
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  agbkf_pkg::word_t   numer,
  input  agbkf_pkg::word_t   denom,
  output logic               done,
  output agbkf_pkg::word_t   quot
);
  import agbkf_pkg::*;

  logic                  busy;
  logic [4:0]            cnt;
  logic [DATA_W-1:0]     rem;
  logic [DATA_W-1:0]     low;
  logic [DATA_W-1:0]     den;
  logic                  neg;
  logic                  ovf;

  logic [DATA_W-1:0]     mag;
  logic [2*DATA_W-1:0]   num_full;
  logic                  ovf_now;
  logic [DATA_W:0]       rem_w;
  logic                  ge;
  logic [DATA_W:0]       rem_sub;

  // Magnitude of the scaled numerator; the quotient overflows a word exactly
  // when its upper half is not below the divisor.
  always_comb begin
    mag      = numer[DATA_W-1] ? DATA_W'(-numer) : DATA_W'(numer);
    num_full = {{DATA_W{1'b0}}, mag} << FRAC_BITS;
    ovf_now  = num_full[2*DATA_W-1:DATA_W] >= DATA_W'(denom);
  end

  // One restoring step per cycle.
  always_comb begin
    rem_w   = {rem, low[DATA_W-1]};
    ge      = rem_w >= {1'b0, den};
    rem_sub = rem_w - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= !ovf_now;
        done <= ovf_now;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (&cnt) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (start) begin
      neg <= numer[DATA_W-1];
      ovf <= ovf_now;
      den <= DATA_W'(denom);
      rem <= num_full[2*DATA_W-1:DATA_W];
      low <= num_full[DATA_W-1:0];
    end else if (busy) begin
      rem <= ge ? rem_sub[DATA_W-1:0] : rem_w[DATA_W-1:0];
      low <= {low[DATA_W-2:0], ge};
    end
  end

  // Apply the sign and saturate.
  always_comb begin
    if (neg) begin
      quot = (ovf || low[DATA_W-1]) ? WORD_MIN : word_t'(-low);
    end else begin
      quot = (ovf || low[DATA_W-1]) ? WORD_MAX : word_t'(low);
    end
  end

endmodule

// ===== tb/angle_gyro_bias_kalman_filter_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// angle_gyro_bias_kalman_filter_test: self-checking bench for the tilt filter
// Drives samples through the filter under a range of register settings. A
// fixed-point predictor keeps its own angle, bias and covariance and works
// out every estimate. Each estimate beat is checked against the oldest
// prediction. Both channels idle at random, and the run also covers long
// output stalls, unbroken streams and drained pauses.
// ----------------------------------------------------------------------------
module angle_gyro_bias_kalman_filter_test;
  import agbkf_pkg::*;

  localparam int FRAC          = 20;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 200;
  localparam int STALL_CYCLES  = 600;

  localparam word_t Q_ONE = 32'sd1 <<< FRAC;
  localparam logic [CFG_W-1:0] REG_FULL = {CFG_W{1'b1}};
  localparam logic [CFG_W-1:0] REG_ONE  = 21'd1048576;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  agbkf_in_if  sample_ch ();
  agbkf_out_if estimate_ch ();

  angle_gyro_bias_kalman_filter #(
    .FRAC_BITS(FRAC)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .sample   (sample_ch),
    .estimate (estimate_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Filter state and register copies, as after reset.
  logic [CFG_W-1:0] step_reg        = RST_TIME_STEP;
  logic [CFG_W-1:0] angle_noise_reg = RST_ANGLE_NOISE;
  logic [CFG_W-1:0] bias_noise_reg  = RST_BIAS_NOISE;
  logic [CFG_W-1:0] meas_noise_reg  = RST_MEAS_NOISE;
  word_t est_angle = '0;
  word_t est_bias  = '0;
  word_t p_aa = '0;
  word_t p_ab = '0;
  word_t p_ba = '0;
  word_t p_bb = '0;

  word_t expected_angles [$];
  int    mismatches        = 0;
  int    samples_sent      = 0;
  int    estimates_checked = 0;
  int    settings_applied  = 0;
  int    cycles            = 0;
  int    stall_left        = 0;
  bit    tx_steady         = 1'b0;
  bit    rx_steady         = 1'b0;

  always #5 clk = ~clk;

  // Saturating fixed-point arithmetic.
  function automatic word_t q_sat(longint v);
    if (v > longint'(WORD_MAX)) return WORD_MAX;
    if (v < longint'(WORD_MIN)) return WORD_MIN;
    return word_t'(v);
  endfunction

  function automatic word_t q_add(word_t a, word_t b);
    return q_sat(longint'(a) + longint'(b));
  endfunction

  function automatic word_t q_sub(word_t a, word_t b);
    return q_sat(longint'(a) - longint'(b));
  endfunction

  // The product is floored by the arithmetic shift.
  function automatic word_t q_mul(word_t a, word_t b);
    longint prod;
    prod = longint'(a) * longint'(b);
    return q_sat(prod >>> FRAC);
  endfunction

  // The quotient truncates toward zero; the divisor is always positive.
  function automatic word_t q_div(word_t n, word_t d);
    longint num;
    num = longint'(n) * (longint'(1) <<< FRAC);
    return q_sat(num / longint'(d));
  endfunction

  // One filter step: predict, gains, correction, covariance update.
  function automatic word_t predict_angle(word_t accel, word_t gyro);
    word_t dt, qa, qb, r, t, inner, s, k0, k1, y, a_old, b_old;
    dt = word_t'({11'b0, step_reg});
    qa = word_t'({11'b0, angle_noise_reg});
    qb = word_t'({11'b0, bias_noise_reg});
    r  = word_t'({11'b0, meas_noise_reg});

    est_angle = q_add(est_angle, q_mul(dt, q_sub(gyro, est_bias)));
    t     = q_mul(dt, p_bb);
    inner = q_add(q_sub(q_sub(t, p_ab), p_ba), qa);
    p_aa  = q_add(p_aa, q_mul(dt, inner));
    p_ab  = q_sub(p_ab, t);
    p_ba  = q_sub(p_ba, t);
    p_bb  = q_add(p_bb, q_mul(qb, dt));

    // A non-positive innovation covariance gives zero gains.
    s = q_add(p_aa, r);
    if (s > 0) begin
      k0 = q_div(p_aa, s);
      k1 = q_div(p_ba, s);
    end else begin
      k0 = '0;
      k1 = '0;
    end

    y         = q_sub(accel, est_angle);
    est_angle = q_add(est_angle, q_mul(k0, y));
    est_bias  = q_add(est_bias, q_mul(k1, y));

    a_old = p_aa;
    b_old = p_ab;
    p_aa  = q_sub(p_aa, q_mul(k0, a_old));
    p_ab  = q_sub(p_ab, q_mul(k0, b_old));
    p_ba  = q_sub(p_ba, q_mul(k1, a_old));
    p_bb  = q_sub(p_bb, q_mul(k1, b_old));
    return est_angle;
  endfunction

  function automatic word_t corner_word();
    case ($urandom_range(4))
      0:       return WORD_MIN;
      1:       return WORD_MAX;
      2:       return '0;
      3:       return -32'sd1;
      default: return 32'sd1;
    endcase
  endfunction

  // Mostly plausible angles and rates, then full-range words and corners.
  function automatic void rand_sample(output word_t accel, output word_t gyro);
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 70) begin
      accel = word_t'(32'($urandom_range(0, 8388608)) - 32'd4194304);
      gyro  = word_t'(32'($urandom_range(0, 4194304)) - 32'd2097152);
    end else if (pick < 90) begin
      accel = word_t'($urandom);
      gyro  = word_t'($urandom);
    end else begin
      accel = corner_word();
      gyro  = corner_word();
    end
  endfunction

  // A register value in a range, or with wild set, often a corner value.
  function automatic logic [CFG_W-1:0] rand_reg(int unsigned lo, int unsigned hi, bit wild);
    if (wild && $urandom_range(1) == 1) begin
      case ($urandom_range(3))
        0:       return '0;
        1:       return 21'd1;
        2:       return REG_ONE;
        default: return REG_FULL;
      endcase
    end
    return CFG_W'($urandom_range(lo, hi));
  endfunction

  // Offer one sample, with a random gap first, and predict on acceptance.
  task automatic send_sample(word_t accel, word_t gyro);
    int gap;
    gap = 0;
    if (!tx_steady) begin
      if ($urandom_range(99) < 5) begin
        gap = $urandom_range(1, 120);
      end else begin
        while ($urandom_range(99) < 33) gap++;
      end
    end
    repeat (gap) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sample_ch.valid       <= 1'b1;
    sample_ch.accel_angle <= accel;
    sample_ch.gyro_rate   <= gyro;
    do @(posedge clk); while (sample_ch.ready !== 1'b1);
    expected_angles.push_back(predict_angle(accel, gyro));
    samples_sent++;
  endtask

  task automatic send_random(int count);
    word_t accel, gyro;
    repeat (count) begin
      rand_sample(accel, gyro);
      send_sample(accel, gyro);
    end
  endtask

  // Stop offering and wait until every predicted estimate has arrived.
  task automatic wait_for_estimates();
    sample_ch.valid <= 1'b0;
    while (expected_angles.size() != 0) @(posedge clk);
  endtask

  // One register write; the caller lowers the write enable after a group.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      CFG_TIME_STEP:   step_reg        = val;
      CFG_ANGLE_NOISE: angle_noise_reg = val;
      CFG_BIAS_NOISE:  bias_noise_reg  = val;
      CFG_MEAS_NOISE:  meas_noise_reg  = val;
      default: ;
    endcase
  endtask

  task automatic apply_config(logic [CFG_W-1:0] dt, logic [CFG_W-1:0] qa,
                              logic [CFG_W-1:0] qb, logic [CFG_W-1:0] r);
    wait_for_estimates();
    write_reg(CFG_TIME_STEP, dt);
    write_reg(CFG_ANGLE_NOISE, qa);
    write_reg(CFG_BIAS_NOISE, qb);
    write_reg(CFG_MEAS_NOISE, r);
    cfg_we <= 1'b0;
    settings_applied++;
  endtask

  // With zero noise and a fresh covariance the innovation covariance is
  // zero, so both gains must be zero and only the gyro moves the angle.
  task automatic test_zero_innovation();
    apply_config(RST_TIME_STEP, '0, '0, '0);
    send_sample(Q_ONE, Q_ONE / 2);
    send_sample(WORD_MAX, WORD_MIN);
    send_sample(-Q_ONE, Q_ONE);
  endtask

  // Field extremes under the default registers.
  task automatic test_input_extremes();
    apply_config(RST_TIME_STEP, RST_ANGLE_NOISE, RST_BIAS_NOISE, RST_MEAS_NOISE);
    send_sample('0, '0);
    send_sample(WORD_MAX, '0);
    send_sample(WORD_MIN, '0);
    send_sample('0, WORD_MAX);
    send_sample('0, WORD_MIN);
    send_sample(WORD_MAX, WORD_MAX);
    send_sample(WORD_MIN, WORD_MIN);
    send_sample(32'sd1, -32'sd1);
  endtask

  // A zero time step freezes the prediction.
  task automatic test_frozen_prediction();
    wait_for_estimates();
    write_reg(CFG_TIME_STEP, '0);
    cfg_we <= 1'b0;
    settings_applied++;
    send_sample(Q_ONE, 2 * Q_ONE);
    send_sample(-Q_ONE / 2, WORD_MAX);
    send_sample('0, WORD_MIN);
  endtask

  // A write to an index past the register list changes nothing.
  task automatic test_unlisted_register();
    wait_for_estimates();
    write_reg(CFG_IDX_W'($urandom_range(CFG_MEAS_NOISE + 1, {CFG_IDX_W{1'b1}})), REG_FULL);
    cfg_we <= 1'b0;
    send_sample(Q_ONE, '0);
    send_sample(-Q_ONE, Q_ONE);
  endtask

  // Plausible register settings with random samples.
  task automatic test_random_settings();
    repeat (4) begin
      apply_config(rand_reg(1, 16384, 1'b0), rand_reg(0, 8192, 1'b0),
                   rand_reg(0, 16384, 1'b0), rand_reg(1, 262144, 1'b0));
      send_random(70);
    end
  endtask

  // Neither side idles for a long stretch.
  task automatic test_steady_stream();
    wait_for_estimates();
    tx_steady = 1'b1;
    rx_steady <= 1'b1;
    send_random(50);
    wait_for_estimates();
    tx_steady = 1'b0;
    rx_steady <= 1'b0;
  endtask

  // The receiver holds off while samples keep coming, so the filter fills
  // up and must stall its input.
  task automatic test_output_stall();
    wait_for_estimates();
    stall_left <= STALL_CYCLES;
    tx_steady = 1'b1;
    send_random(10);
    tx_steady = 1'b0;
    wait_for_estimates();
  endtask

  // The sender pauses mid-stream until every estimate has come back.
  task automatic test_drain_pause();
    send_random(20);
    wait_for_estimates();
    send_random(20);
  endtask

  // Register extremes, which drive the covariance into saturation.
  task automatic test_extreme_settings();
    apply_config(REG_FULL, REG_FULL, REG_FULL, 21'd1);
    send_random(30);
    apply_config(REG_ONE, REG_ONE, '0, REG_ONE);
    send_random(30);
    repeat (2) begin
      apply_config(rand_reg(1, 16384, 1'b1), rand_reg(0, 8192, 1'b1),
                   rand_reg(0, 16384, 1'b1), rand_reg(1, 262144, 1'b1));
      send_random(30);
    end
  endtask

  // Receiver: random stalls, forced hold-off, or always ready.
  always @(posedge clk) begin
    if (rst) begin
      estimate_ch.ready <= 1'b0;
    end else if (stall_left != 0) begin
      estimate_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (rx_steady) begin
      estimate_ch.ready <= 1'b1;
    end else begin
      estimate_ch.ready <= ($urandom_range(99) >= 33);
    end
  end

  // Check each estimate beat against the oldest prediction.
  always @(posedge clk) begin : check_estimate
    word_t want;
    if (!rst && estimate_ch.valid === 1'b1 && estimate_ch.ready === 1'b1) begin
      if (expected_angles.size() == 0) begin
        $error("angle_estimate beat with no sample waiting: actual %0d",
               estimate_ch.angle_estimate);
        mismatches++;
      end else begin
        want = expected_angles.pop_front();
        estimates_checked++;
        if (estimate_ch.angle_estimate !== want) begin
          $error("angle_estimate mismatch: expected %0d, actual %0d",
                 want, estimate_ch.angle_estimate);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d estimates outstanding",
               cycles, expected_angles.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    sample_ch.valid       = 1'b0;
    sample_ch.accel_angle = '0;
    sample_ch.gyro_rate   = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_zero_innovation();
    test_input_extremes();
    test_frozen_prediction();
    test_unlisted_register();
    test_random_settings();
    test_steady_stream();
    test_output_stall();
    test_drain_pause();
    test_extreme_settings();

    // Let any stray beat show up before the verdict.
    wait_for_estimates();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d samples and checked %0d estimates over %0d register settings,",
             samples_sent, estimates_checked, settings_applied);
    $display("including zero gains, frozen prediction, saturation and long stalls.");
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
